[sv/vt4_pkg.sv]
`timescale 1ns / 1ps

package vt4_pkg;

    // Widths of the fixed fields.
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned INDEX_W    = 2;
    localparam int unsigned DIM        = 4;
    localparam int unsigned PROD_W     = 2 * DATA_W;
    localparam int unsigned PAIR_W     = PROD_W + 1;
    localparam int unsigned ACC_W      = PROD_W + 2;

    // Input beat layout, lowest bit first.
    localparam int unsigned ROW_LSB    = 0;
    localparam int unsigned COL_LSB    = ROW_LSB + INDEX_W;
    localparam int unsigned COEF_LSB   = COL_LSB + INDEX_W;
    localparam int unsigned VEC_LSB    = COEF_LSB + DATA_W;
    localparam int unsigned S_FIELDS_W = VEC_LSB + DIM * DATA_W;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = DIM * DATA_W;

    // Command codes carried on s_tuser.
    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_TRANSFORM = 1'b1;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [INDEX_W-1:0]       index_t;

endpackage

[sv/vertex_transform_4x4_top.sv]
`timescale 1ns / 1ps

// Vertex transform: holds a 4x4 matrix of signed fixed-point coefficients (FRAC_BITS
// fraction bits, Q16.16 by default) that comes out of reset as the identity matrix. Each
// input beat is either a load (s_tuser low), which writes one coefficient at the given row
// and column and produces no output beat, or a transform (s_tuser high), which produces
// one output beat holding the matrix times the vector (x, y, z, w). Each row is a sum of
// four exact 64-bit products, shifted right arithmetically by FRAC_BITS (rounding toward
// minus infinity) and saturated to 32 bits; m_tuser flags that any component was clipped.
// The block takes one beat per clock while s_tready is high. A transform passes through
// the product, pair-sum and row-total registers into the output register: the sixteen
// 32x32 multipliers form the first stage, two adder stages reduce each row, and the shift
// and saturation stage feeds the output register. Every stage has its own valid bit and
// moves forward whenever the stage after it is empty or moving, so bubbles are squeezed
// out and a stalled output only holds the pipeline back once it has filled. A load takes
// effect for every transform accepted after it; transforms already in flight keep the
// coefficients they were multiplied with.

module vertex_transform_4x4_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // From bit 0 up: row_index[1:0], column_index[1:0], coefficient[31:0],
    // in_x[31:0], in_y[31:0], in_z[31:0], in_w[31:0], then zero fill.
    input  logic [vt4_pkg::S_TDATA_W-1:0]  s_tdata,
    // Bit 0: command (0 load a coefficient, 1 transform the vector).
    input  logic                           s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // From bit 0 up: out_x[31:0], out_y[31:0], out_z[31:0], out_w[31:0].
    output logic [vt4_pkg::M_TDATA_W-1:0]  m_tdata,
    // Bit 0: saturated.
    output logic                           m_tuser
);

    localparam int unsigned DIM     = vt4_pkg::DIM;
    localparam int unsigned DATA_W  = vt4_pkg::DATA_W;
    localparam int unsigned ACC_W   = vt4_pkg::ACC_W;
    // Bits of the accumulator above the kept result must all equal its sign bit.
    localparam int unsigned SAT_LSB = DATA_W - 1 + FRAC_BITS;
    localparam vt4_pkg::word_t ONE  = vt4_pkg::word_t'(64'd1 << FRAC_BITS);
    localparam vt4_pkg::word_t POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam vt4_pkg::word_t NEG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Matrix storage, row-major.
    vt4_pkg::word_t coef_reg [DIM][DIM];

    // Pipeline registers.
    logic           v1_reg, v2_reg, v3_reg, m_valid_reg;
    vt4_pkg::prod_t prod_reg [DIM][DIM];
    vt4_pkg::pair_t pair_reg [DIM][2];
    vt4_pkg::acc_t  acc_reg  [DIM];
    logic [vt4_pkg::M_TDATA_W-1:0] m_data_reg;
    logic           m_sat_reg;

    vt4_pkg::word_t vec      [DIM];
    vt4_pkg::prod_t prod_next [DIM][DIM];
    vt4_pkg::pair_t pair_next [DIM][2];
    vt4_pkg::acc_t  acc_next  [DIM];
    logic [vt4_pkg::M_TDATA_W-1:0] m_data_next;
    logic           m_sat_next;

    logic           en1, en2, en3, en_out;
    logic           in_fire, load_fire, xform_fire;
    vt4_pkg::index_t ld_row, ld_col;
    vt4_pkg::word_t  ld_coef;

    // Each stage may load when it is empty or its content moves on this cycle.
    assign en_out = !m_valid_reg || m_tready;
    assign en3    = !v3_reg || en_out;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;

    assign s_tready   = en1;
    assign in_fire    = s_tvalid && s_tready;
    assign load_fire  = in_fire && (s_tuser == vt4_pkg::CMD_LOAD);
    assign xform_fire = in_fire && (s_tuser == vt4_pkg::CMD_TRANSFORM);

    assign ld_row  = s_tdata[vt4_pkg::ROW_LSB +: vt4_pkg::INDEX_W];
    assign ld_col  = s_tdata[vt4_pkg::COL_LSB +: vt4_pkg::INDEX_W];
    assign ld_coef = vt4_pkg::word_t'(s_tdata[vt4_pkg::COEF_LSB +: DATA_W]);

    // Coefficient writes. Reset restores the identity matrix.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < DIM; r++) begin
                for (int c = 0; c < DIM; c++) begin
                    coef_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (load_fire) begin
            coef_reg[ld_row][ld_col] <= ld_coef;
        end
    end

    // Stage 1: sixteen independent products straight from the input beat.
    always_comb begin
        for (int k = 0; k < DIM; k++) begin
            vec[k] = vt4_pkg::word_t'(s_tdata[vt4_pkg::VEC_LSB + k * DATA_W +: DATA_W]);
        end
        for (int r = 0; r < DIM; r++) begin
            for (int k = 0; k < DIM; k++) begin
                prod_next[r][k] = vt4_pkg::prod_t'(coef_reg[r][k]) * vt4_pkg::prod_t'(vec[k]);
            end
        end
    end

    // Stage 2: pairwise sums; stage 3: row totals.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            pair_next[r][0] = vt4_pkg::pair_t'(prod_reg[r][0]) + vt4_pkg::pair_t'(prod_reg[r][1]);
            pair_next[r][1] = vt4_pkg::pair_t'(prod_reg[r][2]) + vt4_pkg::pair_t'(prod_reg[r][3]);
            acc_next[r]     = vt4_pkg::acc_t'(pair_reg[r][0]) + vt4_pkg::acc_t'(pair_reg[r][1]);
        end
    end

    // Stage 4: drop the fraction bits and clip each row to 32 bits.
    always_comb begin
        logic [ACC_W-1-SAT_LSB:0] top;
        vt4_pkg::acc_t            shifted;
        m_sat_next  = 1'b0;
        m_data_next = '0;
        for (int r = 0; r < DIM; r++) begin
            top     = acc_reg[r][ACC_W-1:SAT_LSB];
            shifted = acc_reg[r] >>> FRAC_BITS;
            if ((&top) || !(|top)) begin
                m_data_next[r * DATA_W +: DATA_W] = shifted[DATA_W-1:0];
            end else begin
                m_sat_next = 1'b1;
                m_data_next[r * DATA_W +: DATA_W] = acc_reg[r][ACC_W-1] ? NEG_MIN : POS_MAX;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= xform_fire;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
            if (en_out) begin
                m_valid_reg <= v3_reg;
            end
        end
    end

    // Data path registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (en1 && xform_fire) begin
            prod_reg <= prod_next;
        end
        if (en2 && v1_reg) begin
            pair_reg <= pair_next;
        end
        if (en3 && v2_reg) begin
            acc_reg <= acc_next;
        end
        if (en_out && v3_reg) begin
            m_data_reg <= m_data_next;
            m_sat_reg  <= m_sat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_sat_reg;

`ifndef SYNTH
    // A load beat lands in the addressed coefficient.
    a_load_written: assert property (@(posedge aclk) disable iff (!aresetn)
        load_fire |=> coef_reg[$past(ld_row)][$past(ld_col)] == $past(ld_coef))
        else $error("coefficient load not written");

    // A transform beat always enters the first stage.
    a_xform_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        xform_fire |=> v1_reg)
        else $error("transform beat lost at pipeline entry");

    // A finished row total that moves on shows up at the output.
    a_last_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && en_out) |=> m_valid_reg)
        else $error("result lost before output register");

    // A load never creates an output beat on its own.
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_fire && en1) |=> !v1_reg)
        else $error("load beat entered the transform pipeline");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule
